### design/tcfd_pkg.sv
`default_nettype none

package tcfd_pkg;

  localparam int WinW     = 64;
  localparam int SymW     = 8;
  localparam int ErrW     = 3;
  localparam int MinuteW  = 7;
  localparam int HourW    = 6;
  localparam int DayW     = 6;
  localparam int MonthW   = 5;
  localparam int YearW    = 8;

  // frame bit positions
  localparam int StartIdx   = 0;
  localparam int MarkIdx    = 20;
  localparam int MinLo      = 21;
  localparam int MinHi      = 28;
  localparam int HourLo     = 29;
  localparam int HourHi     = 35;
  localparam int DateLo     = 36;
  localparam int DateHi     = 58;

  localparam logic [ErrW-1:0] ERR_OK     = 3'd0;
  localparam logic [ErrW-1:0] ERR_START  = 3'd1;
  localparam logic [ErrW-1:0] ERR_MARK   = 3'd2;
  localparam logic [ErrW-1:0] ERR_MINUTE = 3'd3;
  localparam logic [ErrW-1:0] ERR_HOUR   = 3'd4;
  localparam logic [ErrW-1:0] ERR_DATE   = 3'd5;

  typedef struct packed {
    logic               frame_valid;
    logic [ErrW-1:0]    error_code;
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day_of_month;
    logic [MonthW-1:0]  month_number;
    logic [YearW-1:0]   year_in_century;
  } frame_res_t;

  // ones digit plus ten times tens digit, 8-bit result; callers truncate
  function automatic logic [7:0] bcd_sum(input logic [3:0] ones, input logic [3:0] tens);
    logic [7:0] t;
    t = {4'd0, tens};
    return {4'd0, ones} + (t << 3) + (t << 1);
  endfunction

endpackage

`default_nettype wire

### design/tcfd_window.sv
`default_nettype none

module tcfd_window (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire logic                      data_bit,
  output logic [tcfd_pkg::WinW-1:0]      window
);

  logic [tcfd_pkg::WinW-1:0] window_r;
  logic [tcfd_pkg::WinW-1:0] window_nxt;

  // newest bit enters at the top, index 0 falls off
  always_comb begin
    window_nxt = window_r;
    if (shift_en) begin
      window_nxt = {data_bit, window_r[tcfd_pkg::WinW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

  assign window = window_r;

endmodule

`default_nettype wire

### design/tcfd_check.sv
`default_nettype none

module tcfd_check (
  input  wire logic [tcfd_pkg::WinW-1:0] window,
  output tcfd_pkg::frame_res_t           res
);

  logic            par_min;
  logic            par_hour;
  logic            par_date;
  logic [tcfd_pkg::ErrW-1:0] err;
  logic [7:0]      min_sum;
  logic [7:0]      hour_sum;
  logic [7:0]      day_sum;
  logic [7:0]      month_sum;
  logic [7:0]      year_sum;

  assign par_min  = ^window[tcfd_pkg::MinHi:tcfd_pkg::MinLo];
  assign par_hour = ^window[tcfd_pkg::HourHi:tcfd_pkg::HourLo];
  assign par_date = ^window[tcfd_pkg::DateHi:tcfd_pkg::DateLo];

  always_comb begin
    priority if (window[tcfd_pkg::StartIdx] != 1'b0) err = tcfd_pkg::ERR_START;
    else if (window[tcfd_pkg::MarkIdx] != 1'b1)      err = tcfd_pkg::ERR_MARK;
    else if (par_min)                                 err = tcfd_pkg::ERR_MINUTE;
    else if (par_hour)                                err = tcfd_pkg::ERR_HOUR;
    else if (par_date)                                err = tcfd_pkg::ERR_DATE;
    else                                              err = tcfd_pkg::ERR_OK;
  end

  assign min_sum   = tcfd_pkg::bcd_sum(window[24:21], {1'b0, window[27:25]});
  assign hour_sum  = tcfd_pkg::bcd_sum(window[32:29], {2'b00, window[34:33]});
  assign day_sum   = tcfd_pkg::bcd_sum(window[39:36], {2'b00, window[41:40]});
  assign month_sum = tcfd_pkg::bcd_sum(window[48:45], {3'b000, window[49]});
  assign year_sum  = tcfd_pkg::bcd_sum(window[53:50], window[57:54]);

  always_comb begin
    res             = '0;
    res.error_code  = err;
    if (err == tcfd_pkg::ERR_OK) begin
      res.frame_valid     = 1'b1;
      res.minute          = min_sum[tcfd_pkg::MinuteW-1:0];
      res.hour            = hour_sum[tcfd_pkg::HourW-1:0];
      res.day_of_month    = day_sum[tcfd_pkg::DayW-1:0];
      res.month_number    = month_sum[tcfd_pkg::MonthW-1:0];
      res.year_in_century = year_sum[tcfd_pkg::YearW-1:0];
    end
  end

endmodule

`default_nettype wire

### design/time_code_frame_decoder.sv
// A data bit enters the bit window; its check then loads the result register (out_valid).
// One request per cycle while not stalled; the shift window and result register overlap.
// Symbols other than 0 or 1 are accepted but produce no result.
// in_stall rises only when a checked frame is waiting and the result register is stalled.
// Reset (rst_n low, synchronous) clears the bit window to zeros and empties both stages.
`default_nettype none

module time_code_frame_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcfd_pkg::SymW-1:0]     in_symbol,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_frame_valid,
  output logic [tcfd_pkg::ErrW-1:0]          out_error_code,
  output logic [tcfd_pkg::MinuteW-1:0]       out_minute,
  output logic [tcfd_pkg::HourW-1:0]         out_hour,
  output logic [tcfd_pkg::DayW-1:0]          out_day_of_month,
  output logic [tcfd_pkg::MonthW-1:0]        out_month_number,
  output logic [tcfd_pkg::YearW-1:0]         out_year_in_century
);

  logic                      in_acc;
  logic                      data_acc;
  logic                      res_ld;
  logic                      win_vld_r;
  logic                      win_vld_nxt;
  logic                      out_vld_r;
  logic                      out_vld_nxt;
  logic [tcfd_pkg::WinW-1:0] window;
  tcfd_pkg::frame_res_t      chk_res;
  tcfd_pkg::frame_res_t      res_r;

  assign res_ld   = !out_vld_r || !out_stall;
  assign in_stall = win_vld_r && !res_ld;
  assign in_acc   = in_valid && !in_stall;
  assign data_acc = in_acc && (in_symbol[tcfd_pkg::SymW-1:1] == '0);

  tcfd_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (data_acc),
    .data_bit (in_symbol[0]),
    .window   (window)
  );

  tcfd_check u_check (
    .window (window),
    .res    (chk_res)
  );

  always_comb begin
    win_vld_nxt = win_vld_r;
    if (data_acc) begin
      win_vld_nxt = 1'b1;
    end else if (res_ld) begin
      win_vld_nxt = 1'b0;
    end
    out_vld_nxt = res_ld ? win_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      win_vld_r <= win_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld && win_vld_r) begin
      res_r <= chk_res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_frame_valid     = res_r.frame_valid;
  assign out_error_code      = res_r.error_code;
  assign out_minute          = res_r.minute;
  assign out_hour            = res_r.hour;
  assign out_day_of_month    = res_r.day_of_month;
  assign out_month_number    = res_r.month_number;
  assign out_year_in_century = res_r.year_in_century;

  a_valid_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.frame_valid == (res_r.error_code == tcfd_pkg::ERR_OK)))
    else $error("frame_valid disagrees with error code");

  a_zero_on_err : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.frame_valid) |-> (res_r.minute == '0 && res_r.hour == '0 &&
      res_r.day_of_month == '0 && res_r.month_number == '0 &&
      res_r.year_in_century == '0))
    else $error("date fields not cleared on frame error");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (win_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_bit_pending : assert property (@(posedge clk) disable iff (!rst_n)
    data_acc |=> win_vld_r)
    else $error("accepted data bit left no pending frame check");

  a_gap_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !data_acc && !win_vld_r && res_ld) |=> !win_vld_r)
    else $error("ignored symbol created a frame check");

endmodule

`default_nettype wire
